// ----- hw/rtl/bpm_pkg.sv -----
// Package with the shared types, codes and reset values of the battery power mode machine.
`default_nettype none

package bpm_pkg;

  // Field widths of the channels.
  localparam int unsigned CmdW   = 3;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned VoltW  = 16;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // Command codes carried by an input item.
  typedef enum logic [CmdW-1:0] {
    CMD_UPDATE  = 3'd0,
    CMD_PING    = 3'd1,
    CMD_COLLECT = 3'd2,
    CMD_SLEEP   = 3'd3,
    CMD_WAKE    = 3'd4
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACTIVE_THRESHOLD  = 2'd0,
    CFG_STANDBY_THRESHOLD = 2'd1,
    CFG_PING_PERIOD       = 2'd2,
    CFG_IDLE_TIMEOUT      = 2'd3
  } cfg_idx_e;

  // Power mode state, one-hot.
  typedef enum logic [2:0] {
    ST_ACTIVE  = 3'b001,
    ST_STANDBY = 3'b010,
    ST_SLEEP   = 3'b100
  } state_e;

  // Mode codes as reported in a result item.
  localparam logic [ModeW-1:0] MODE_ACTIVE  = 2'd0;
  localparam logic [ModeW-1:0] MODE_STANDBY = 2'd1;
  localparam logic [ModeW-1:0] MODE_SLEEP   = 2'd2;

  // Reset values.
  localparam logic [VoltW-1:0] RST_ACTIVE_THRESHOLD  = 16'd13000;
  localparam logic [VoltW-1:0] RST_STANDBY_THRESHOLD = 16'd11800;
  localparam logic [TimeW-1:0] RST_PING_PERIOD       = 32'd60000;
  localparam logic [TimeW-1:0] RST_IDLE_TIMEOUT      = 32'd1800000;
  localparam logic [TimeW-1:0] TIME_NEVER            = '1;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [TimeW-1:0] timestamp_ms;
    logic [VoltW-1:0] voltage_mv;
    logic             motion;
    logic [TimeW-1:0] interval_ms;
  } item_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             fire;
  } result_t;

  typedef struct packed {
    logic [VoltW-1:0] active_threshold_mv;
    logic [VoltW-1:0] standby_threshold_mv;
    logic [TimeW-1:0] ping_period_ms;
    logic [TimeW-1:0] idle_timeout_ms;
  } cfg_t;

  // Handshake status passed from the output register to the input register.
  typedef struct packed {
    logic can_load;
  } out_status_t;

  // Translate the one-hot state into the reported mode code.
  function automatic logic [ModeW-1:0] state_to_mode(state_e st);
    logic [ModeW-1:0] m;
    case (st)
      ST_ACTIVE:  m = MODE_ACTIVE;
      ST_STANDBY: m = MODE_STANDBY;
      default:    m = MODE_SLEEP;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bpm_if.sv -----
// Channel interfaces of the battery power mode machine: input items, result items, configuration.
`default_nettype none

interface bpm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [31:0] timestamp_ms;
  logic [15:0] voltage_mv;
  logic        motion;
  logic [31:0] interval_ms;

  modport source (
    output valid, command, timestamp_ms, voltage_mv, motion, interval_ms,
    input  ready
  );
  modport sink (
    input  valid, command, timestamp_ms, voltage_mv, motion, interval_ms,
    output ready
  );
endinterface

interface bpm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic       fire;

  modport source (output valid, mode, fire, input ready);
  modport sink (input valid, mode, fire, output ready);
endinterface

interface bpm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bpm_cfg_regs.sv -----
// Configuration registers of the battery power mode machine.
`default_nettype none

module bpm_cfg_regs (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bpm_cfg_if.sink    cfg_i,
  output bpm_pkg::cfg_t cfg_o
);
  import bpm_pkg::*;

  cfg_t cfg_q;

  // Writes are always taken.
  assign cfg_i.ready = 1'b1;

  // Register file, one write per accepted configuration item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_threshold_mv  <= RST_ACTIVE_THRESHOLD;
      cfg_q.standby_threshold_mv <= RST_STANDBY_THRESHOLD;
      cfg_q.ping_period_ms       <= RST_PING_PERIOD;
      cfg_q.idle_timeout_ms      <= RST_IDLE_TIMEOUT;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_ACTIVE_THRESHOLD:  cfg_q.active_threshold_mv  <= cfg_i.data[VoltW-1:0];
        CFG_STANDBY_THRESHOLD: cfg_q.standby_threshold_mv <= cfg_i.data[VoltW-1:0];
        CFG_PING_PERIOD:       cfg_q.ping_period_ms       <= cfg_i.data;
        CFG_IDLE_TIMEOUT:      cfg_q.idle_timeout_ms      <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bpm_in_reg.sv -----
// Input register: holds one accepted item until the core has processed it.
`default_nettype none

module bpm_in_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  bpm_in_if.sink                 in_i,
  input  bpm_pkg::out_status_t   out_status_i,
  output logic                   valid_o,
  output bpm_pkg::item_t         item_o,
  output logic                   advance_o
);
  import bpm_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;

  // The held item moves on whenever the result register can take its result.
  assign advance_o = valid_q && out_status_i.can_load;
  assign in_i.ready = !valid_q || advance_o;
  assign accept = in_i.valid && in_i.ready;

  assign valid_d = accept || (valid_q && !advance_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload capture needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.command      <= in_i.command;
      item_q.timestamp_ms <= in_i.timestamp_ms;
      item_q.voltage_mv   <= in_i.voltage_mv;
      item_q.motion       <= in_i.motion;
      item_q.interval_ms  <= in_i.interval_ms;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bpm_core.sv -----
// Power mode state and the single-pass decision logic for one item.
`default_nettype none

module bpm_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  bpm_pkg::cfg_t      cfg_i,
  input  bpm_pkg::item_t     item_i,
  input  wire logic          advance_i,
  output bpm_pkg::result_t   result_o
);
  import bpm_pkg::*;

  state_e           state_q, state_d;
  logic [TimeW-1:0] entry_q, entry_d;
  logic [TimeW-1:0] ping_q, ping_d;
  logic [TimeW-1:0] collect_q, collect_d;
  logic             seen_q, seen_d;
  logic             fire;

  logic [TimeW-1:0] idle_elapsed;
  logic [TimeW-1:0] ping_elapsed;
  logic [TimeW-1:0] collect_elapsed;
  logic             below_standby;
  logic             below_active;

  // Wrapping elapsed times and threshold compares.
  assign idle_elapsed    = item_i.timestamp_ms - entry_q;
  assign ping_elapsed    = item_i.timestamp_ms - ping_q;
  assign collect_elapsed = item_i.timestamp_ms - collect_q;
  assign below_standby   = item_i.voltage_mv < cfg_i.standby_threshold_mv;
  assign below_active    = item_i.voltage_mv < cfg_i.active_threshold_mv;

  // Next state for the item held in the input register.
  always_comb begin
    state_d   = state_q;
    entry_d   = entry_q;
    ping_d    = ping_q;
    collect_d = collect_q;
    seen_d    = seen_q;
    fire      = 1'b0;
    case (cmd_e'(item_i.command))
      CMD_UPDATE: begin
        case (state_q)
          ST_ACTIVE: begin
            if (below_standby) begin
              state_d = ST_SLEEP;
            end else if (below_active) begin
              state_d = ST_STANDBY;
              entry_d = item_i.timestamp_ms;
            end
          end
          ST_STANDBY: begin
            if (!below_active || item_i.motion) begin
              state_d = ST_ACTIVE;
            end else if (below_standby) begin
              state_d = ST_SLEEP;
            end else if (idle_elapsed >= cfg_i.idle_timeout_ms) begin
              state_d = ST_SLEEP;
            end
          end
          default: ;
        endcase
      end
      CMD_PING: begin
        if (state_q == ST_STANDBY && ping_elapsed >= cfg_i.ping_period_ms) begin
          ping_d = item_i.timestamp_ms;
          fire   = 1'b1;
        end
      end
      CMD_COLLECT: begin
        // The first collect in active mode fires at once.
        if (state_q == ST_ACTIVE && (!seen_q || collect_elapsed >= item_i.interval_ms)) begin
          collect_d = item_i.timestamp_ms;
          seen_d    = 1'b1;
          fire      = 1'b1;
        end
      end
      CMD_SLEEP: begin
        state_d = ST_SLEEP;
      end
      CMD_WAKE: begin
        state_d = ST_ACTIVE;
        entry_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_ACTIVE;
      entry_q   <= '0;
      ping_q    <= '0;
      collect_q <= TIME_NEVER;
      seen_q    <= 1'b0;
    end else if (advance_i) begin
      state_q   <= state_d;
      entry_q   <= entry_d;
      ping_q    <= ping_d;
      collect_q <= collect_d;
      seen_q    <= seen_d;
    end
  end

  assign result_o.mode = state_to_mode(state_d);
  assign result_o.fire = fire;

endmodule

`default_nettype wire

// ----- hw/rtl/bpm_out_reg.sv -----
// Result register: presents one result item until the receiver takes it.
`default_nettype none

module bpm_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  bpm_pkg::result_t       result_i,
  output bpm_pkg::out_status_t   status_o,
  bpm_out_if.source              out_o
);
  import bpm_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  // A new result may enter when the register is empty or being emptied.
  assign status_o.can_load = !valid_q || out_o.ready;
  assign valid_d = load_i || (valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_o.valid = valid_q;
  assign out_o.mode  = result_q.mode;
  assign out_o.fire  = result_q.fire;

endmodule

`default_nettype wire

// ----- hw/rtl/battery_power_mode_fsm.sv -----
// Top level of the battery power mode machine.
//
// Items arrive on in_i (valid/ready); each carries a command, a millisecond
// timestamp, a voltage sample, a motion flag and a collect interval. Every
// item produces exactly one result item on out_o: the mode after the item
// and a fire flag for ping and collect queries.
// An accepted item is registered in the input register and processed by the
// decision logic once the result register can take its result, which is
// then registered there. One item is taken every cycle while out_o is
// ready; the single decision stage and its state registers set that figure.
// When the receiver stalls, the result register holds its item and the input
// register still takes one more item; after that in_i.ready stays low.
// Configuration writes on cfg_i are always accepted and take effect at once;
// they are meant to be made while no item is in flight.
// Reset puts the machine in active mode with the thresholds and times at
// their defaults, clears the ping and standby marks and marks collect as
// never done; both pipeline registers come out of reset empty.
`default_nettype none

module battery_power_mode_fsm (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bpm_in_if.sink     in_i,
  bpm_out_if.source  out_o,
  bpm_cfg_if.sink    cfg_i
);
  import bpm_pkg::*;

  cfg_t        cfg;
  item_t       item;
  result_t     result;
  out_status_t out_status;
  logic        item_valid;
  logic        advance;

  // Configuration registers.
  bpm_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Input register.
  bpm_in_reg u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .out_status_i (out_status),
    .valid_o      (item_valid),
    .item_o       (item),
    .advance_o    (advance)
  );

  // Mode state and decision logic.
  bpm_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .item_i    (item),
    .advance_i (advance),
    .result_o  (result)
  );

  // Result register.
  bpm_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .result_i (result),
    .status_o (out_status),
    .out_o    (out_o)
  );

`ifndef SYNTHESIS
  // Only ping and collect queries may fire.
  a_fire_only_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && result.fire |->
      (item.command == CMD_PING || item.command == CMD_COLLECT))
    else $error("fire raised for a command that is not a query");

  // A force-sleep item always reports deep sleep.
  a_sleep_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && item.command == CMD_SLEEP |-> result.mode == MODE_SLEEP)
    else $error("force sleep did not report deep sleep");

  // A full pipeline with a stalled receiver takes no new item.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid && out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input taken while both registers are full and stalled");

  // A processed item shows up as a result in the following cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_o.valid && out_o.mode == $past(result.mode)
      && out_o.fire == $past(result.fire))
    else $error("result register lost a processed item");
`endif

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the battery power mode machine, with its own prediction of every result.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bpm_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam logic [CmdW-1:0] CmdUnusedFirst = CMD_WAKE + 1'b1;
  localparam logic [CmdW-1:0] CmdUnusedLast = '1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bpm_in_if in_if ();
  bpm_out_if out_if ();
  bpm_cfg_if cfg_if ();

  battery_power_mode_fsm DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Events waiting to be offered, and the results they are due to produce.
  item_t queued_events[$];
  result_t due_results[$];

  // Shadow copy of the configuration and of the mode machine.
  cfg_t cfg_shadow;
  logic [ModeW-1:0] shadow_mode;
  logic [TimeW-1:0] shadow_standby_since;
  logic [TimeW-1:0] shadow_last_ping;
  logic [TimeW-1:0] shadow_last_collect;
  logic shadow_collected;

  logic [TimeW-1:0] clock_ms;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned hold_left;
  int unsigned results_seen;
  int unsigned quiet_cycles;
  int unsigned mismatches;
  logic [7:0] rx_tick;
  result_t wanted;

  always #6 clk_i = ~clk_i;

  // All inputs of the block are known from the very start.
  initial begin
    in_if.valid = 1'b0;
    in_if.command = '0;
    in_if.timestamp_ms = '0;
    in_if.voltage_mv = '0;
    in_if.motion = 1'b0;
    in_if.interval_ms = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_ACTIVE_THRESHOLD;
    cfg_if.data = '0;
  end

  // Apply one event to the shadow machine and return the result it produces.
  function automatic result_t next_power_mode_result(item_t ev);
    result_t r;
    logic [TimeW-1:0] in_standby_ms;
    logic [TimeW-1:0] since_ping_ms;
    logic [TimeW-1:0] since_collect_ms;
    r.fire = 1'b0;
    in_standby_ms = ev.timestamp_ms - shadow_standby_since;
    since_ping_ms = ev.timestamp_ms - shadow_last_ping;
    since_collect_ms = ev.timestamp_ms - shadow_last_collect;
    case (ev.command)
      CMD_UPDATE: begin
        if (shadow_mode == MODE_ACTIVE) begin
          if (ev.voltage_mv < cfg_shadow.standby_threshold_mv) begin
            shadow_mode = MODE_SLEEP;
          end else if (ev.voltage_mv < cfg_shadow.active_threshold_mv) begin
            shadow_mode = MODE_STANDBY;
            shadow_standby_since = ev.timestamp_ms;
          end
        end else if (shadow_mode == MODE_STANDBY) begin
          if (ev.voltage_mv >= cfg_shadow.active_threshold_mv || ev.motion) begin
            shadow_mode = MODE_ACTIVE;
          end else if (ev.voltage_mv < cfg_shadow.standby_threshold_mv) begin
            shadow_mode = MODE_SLEEP;
          end else if (in_standby_ms >= cfg_shadow.idle_timeout_ms) begin
            shadow_mode = MODE_SLEEP;
          end
        end
      end
      CMD_PING: begin
        if (shadow_mode == MODE_STANDBY && since_ping_ms >= cfg_shadow.ping_period_ms) begin
          shadow_last_ping = ev.timestamp_ms;
          r.fire = 1'b1;
        end
      end
      CMD_COLLECT: begin
        if (shadow_mode == MODE_ACTIVE &&
            (!shadow_collected || since_collect_ms >= ev.interval_ms)) begin
          shadow_last_collect = ev.timestamp_ms;
          shadow_collected = 1'b1;
          r.fire = 1'b1;
        end
      end
      CMD_SLEEP: shadow_mode = MODE_SLEEP;
      CMD_WAKE: begin
        shadow_mode = MODE_ACTIVE;
        shadow_standby_since = '0;
      end
      default: ;
    endcase
    r.mode = shadow_mode;
    return r;
  endfunction

  // Voltages cluster on both sides of the two thresholds.
  function automatic logic [VoltW-1:0] pick_voltage();
    case ($urandom_range(0, 7))
      0: return cfg_shadow.active_threshold_mv;
      1: return cfg_shadow.active_threshold_mv - 1'b1;
      2: return cfg_shadow.standby_threshold_mv;
      3: return cfg_shadow.standby_threshold_mv - 1'b1;
      4: return '0;
      5: return '1;
      default: return VoltW'($urandom());
    endcase
  endfunction

  task automatic queue_event(logic [CmdW-1:0] cmd, logic [TimeW-1:0] t,
                             logic [VoltW-1:0] v, logic m, logic [TimeW-1:0] iv);
    item_t ev;
    ev.command = cmd;
    ev.timestamp_ms = t;
    ev.voltage_mv = v;
    ev.motion = m;
    ev.interval_ms = iv;
    queued_events.push_back(ev);
  endtask

  // Random events on a clock that mostly runs forward in steps of up to span.
  task automatic queue_random_events(int unsigned count, int unsigned span);
    item_t ev;
    int unsigned pick;
    int unsigned op;
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      op = $urandom_range(0, 99);
      // Now and then the clock jumps anywhere, backwards included.
      if (pick < 5) clock_ms = $urandom();
      else clock_ms += $urandom_range(0, span);
      ev.timestamp_ms = clock_ms;
      ev.voltage_mv = pick_voltage();
      ev.motion = ($urandom_range(0, 3) == 0);
      ev.interval_ms = (pick < 12) ? $urandom() : $urandom_range(0, span);
      if (op < 35) ev.command = CMD_UPDATE;
      else if (op < 55) ev.command = CMD_PING;
      else if (op < 75) ev.command = CMD_COLLECT;
      else if (op < 82) ev.command = CMD_SLEEP;
      else if (op < 96) ev.command = CMD_WAKE;
      else ev.command = CmdW'($urandom_range(CmdUnusedFirst, CmdUnusedLast));
      queued_events.push_back(ev);
    end
  endtask

  task automatic write_register(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_ACTIVE_THRESHOLD: cfg_shadow.active_threshold_mv = value[VoltW-1:0];
      CFG_STANDBY_THRESHOLD: cfg_shadow.standby_threshold_mv = value[VoltW-1:0];
      CFG_PING_PERIOD: cfg_shadow.ping_period_ms = value;
      default: cfg_shadow.idle_timeout_ms = value;
    endcase
  endtask

  task automatic wait_until_drained();
    while (queued_events.size() != 0 || due_results.size() != 0) @(posedge clk_i);
  endtask

  // One phase: drain, reprogram every register, then random traffic.
  task automatic run_phase(logic [VoltW-1:0] active_mv, logic [VoltW-1:0] standby_mv,
                           logic [TimeW-1:0] ping_ms, logic [TimeW-1:0] idle_ms,
                           int unsigned count, int unsigned span);
    wait_until_drained();
    write_register(CFG_ACTIVE_THRESHOLD, CfgDataW'(active_mv));
    write_register(CFG_STANDBY_THRESHOLD, CfgDataW'(standby_mv));
    write_register(CFG_PING_PERIOD, ping_ms);
    write_register(CFG_IDLE_TIMEOUT, idle_ms);
    queue_random_events(count, span);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        due_results.push_back(next_power_mode_result(queued_events.pop_front()));
      end
      // An offered item stays put until it is taken.
      if (!(in_if.valid && !in_if.ready)) begin
        if (gap_left != 0 || queued_events.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_if.valid <= 1'b0;
        end else begin
          in_if.valid <= 1'b1;
          in_if.command <= queued_events[0].command;
          in_if.timestamp_ms <= queued_events[0].timestamp_ms;
          in_if.voltage_mv <= queued_events[0].voltage_mv;
          in_if.motion <= queued_events[0].motion;
          in_if.interval_ms <= queued_events[0].interval_ms;
          if (burst_left != 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40)
                                                   : $urandom_range(0, 6);
          end
        end
      end
    end
  end

  // Receiver: checks each result against the oldest prediction and stalls on
  // a rotating pattern, with an occasional long hold-off to fill the block.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_tick = '0;
      hold_left = 0;
      results_seen = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (due_results.size() == 0) begin
          $error("result with none expected: mode %0d fire %0d", out_if.mode, out_if.fire);
          mismatches++;
        end else begin
          wanted = due_results.pop_front();
          if (out_if.mode !== wanted.mode) begin
            $error("mode: expected %0d, actual %0d", wanted.mode, out_if.mode);
            mismatches++;
          end
          if (out_if.fire !== wanted.fire) begin
            $error("fire: expected %0d, actual %0d", wanted.fire, out_if.fire);
            mismatches++;
          end
        end
        results_seen++;
        if (results_seen % 160 == 80) hold_left = $urandom_range(40, 90);
      end
      rx_tick++;
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (rx_tick[7:6])
          2'd0: out_if.ready <= 1'b1;
          2'd1: out_if.ready <= ($urandom_range(0, 3) != 0);
          2'd2: out_if.ready <= (rx_tick[2:0] != 3'b000);
          default: out_if.ready <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  // Watchdog: any long stretch without a handshake ends the run.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("battery_power_mode_fsm verification failed");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    mismatches = 0;
    quiet_cycles = 0;
    clock_ms = '0;
    cfg_shadow.active_threshold_mv = RST_ACTIVE_THRESHOLD;
    cfg_shadow.standby_threshold_mv = RST_STANDBY_THRESHOLD;
    cfg_shadow.ping_period_ms = RST_PING_PERIOD;
    cfg_shadow.idle_timeout_ms = RST_IDLE_TIMEOUT;
    shadow_mode = MODE_ACTIVE;
    shadow_standby_since = '0;
    shadow_last_ping = '0;
    shadow_last_collect = TIME_NEVER;
    shadow_collected = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed events at the reset configuration.
    // First collect fires at once, then only once the interval has passed.
    queue_event(CMD_COLLECT, 32'd0, 16'd12500, 1'b0, '1);
    queue_event(CMD_COLLECT, 32'd5, 16'd12500, 1'b0, 32'd10);
    queue_event(CMD_COLLECT, 32'd10, 16'd12500, 1'b0, 32'd10);
    // Ping outside standby and the unused command codes.
    queue_event(CMD_PING, 32'd70000, 16'd12500, 1'b0, '0);
    queue_event(CmdUnusedFirst, '1, '1, 1'b1, '1);
    queue_event(CmdUnusedLast, '0, '0, 1'b0, '0);
    // Into standby, collect refused, ping period edges.
    queue_event(CMD_UPDATE, 32'd100, 16'd12999, 1'b0, '0);
    queue_event(CMD_COLLECT, 32'd200, 16'd12500, 1'b0, '0);
    queue_event(CMD_PING, 32'd100, 16'd12500, 1'b0, '0);
    queue_event(CMD_PING, 32'd60000, 16'd12500, 1'b0, '0);
    queue_event(CMD_PING, 32'd60001, 16'd12500, 1'b0, '0);
    // Idle timeout one short of and exactly at its limit.
    queue_event(CMD_UPDATE, 32'd1800099, 16'd11800, 1'b0, '0);
    queue_event(CMD_UPDATE, 32'd1800100, 16'd11800, 1'b0, '0);
    // Deep sleep ignores updates and pings; only wake leaves it.
    queue_event(CMD_UPDATE, 32'd1800200, '1, 1'b1, '0);
    queue_event(CMD_PING, '1, 16'd12500, 1'b0, '0);
    queue_event(CMD_WAKE, 32'd0, 16'd12500, 1'b0, '0);
    queue_event(CMD_UPDATE, 32'd5, 16'd13000, 1'b0, '0);
    // Standby entered just before the time wraps.
    queue_event(CMD_UPDATE, 32'hFFFF_FFF0, 16'd12000, 1'b0, '0);
    queue_event(CMD_UPDATE, 32'd5, 16'd12000, 1'b0, '0);
    queue_event(CMD_UPDATE, 32'd6, 16'd12000, 1'b1, '0);
    queue_event(CMD_UPDATE, 32'd7, 16'd12000, 1'b0, '0);
    queue_event(CMD_UPDATE, 32'd8, 16'd0, 1'b0, '0);
    queue_event(CMD_SLEEP, 32'd9, 16'd12500, 1'b0, '0);
    queue_event(CMD_WAKE, 32'd10, 16'd12500, 1'b0, '0);
    queue_event(CMD_UPDATE, 32'd11, 16'd11799, 1'b0, '0);

    // Random phases over several settings, the extremes among them.
    run_phase(16'd13000, 16'd11800, 32'd50, 32'd300, 150, 40);
    run_phase('0, '0, '0, '0, 100, 10);
    run_phase('1, '1, '1, '1, 100, 32'hFFFF_FFFF);
    run_phase(16'd9000, 16'd15000, 32'd1, 32'd5, 125, 8);
    run_phase(16'd12500, 16'd12000, 32'd1000, 32'd5000, 150, 700);

    wait_until_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("battery_power_mode_fsm verification clean");
    end else begin
      $display("battery_power_mode_fsm verification failed");
    end
    $finish;
  end

endmodule
